// ===== sv/crt_pkg.sv =====
// Package for the contact reference-count tracker.
// Holds field widths, parameter defaults, action and event codes, the
// controller state type and the controller/datapath command and status structs.
package crt_pkg;

  localparam int ACTION_W         = 2;
  localparam int KEY_W            = 32;
  localparam int OBJ_W            = 8;
  localparam int RES_W            = 2;

  localparam int MAX_CONTACTS_DEF = 32;
  localparam int MAX_OBJECTS_DEF  = 16;
  localparam int KEY_BITS_DEF     = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_BEGIN = 2'd0,
    ACT_END   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [RES_W-1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_EXIT  = 2'd2
  } event_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_SEL  = 6'b000100,
    S_LINK = 6'b001000,
    S_OBJ  = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  typedef struct packed {
    logic capture;
    logic look;
    logic sel;
    logic link;
    logic obj;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== sv/crt_if.sv =====
// Handshake channels of the contact reference-count tracker.
// Depends on crt_pkg for the field widths.
interface crt_in_if;
  logic                        valid;
  logic                        ready;
  logic [crt_pkg::ACTION_W-1:0] action;
  logic [crt_pkg::KEY_W-1:0]    contact_key;
  logic [crt_pkg::OBJ_W-1:0]    peer_object;

  modport source (output valid, action, contact_key, peer_object, input ready);
  modport sink   (input valid, action, contact_key, peer_object, output ready);
endinterface

interface crt_out_if;
  logic                      valid;
  logic                      ready;
  logic [crt_pkg::RES_W-1:0] event_res;
  logic [crt_pkg::OBJ_W-1:0] event_object;
  logic                      table_full;

  modport source (output valid, event_res, event_object, table_full, input ready);
  modport sink   (input valid, event_res, event_object, table_full, output ready);
endinterface

// ===== sv/crt_ctrl.sv =====
// Sequencing state machine of the contact reference-count tracker.
// Depends on crt_pkg for the state type and the command/status structs.
module crt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  crt_pkg::stat_t stat,
  output crt_pkg::cmd_t  cmd
);

  crt_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crt_pkg::S_IDLE: if (in_valid) state_nxt = crt_pkg::S_LOOK;
      crt_pkg::S_LOOK: state_nxt = crt_pkg::S_SEL;
      crt_pkg::S_SEL:  state_nxt = crt_pkg::S_LINK;
      crt_pkg::S_LINK: state_nxt = crt_pkg::S_OBJ;
      crt_pkg::S_OBJ:  state_nxt = crt_pkg::S_UPD;
      // hold until the output register can take the result
      crt_pkg::S_UPD:  if (stat.out_free) state_nxt = crt_pkg::S_IDLE;
      default:         state_nxt = crt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == crt_pkg::S_IDLE);
  assign cmd.capture = in_ready && in_valid;
  assign cmd.look    = (state_r == crt_pkg::S_LOOK);
  assign cmd.sel     = (state_r == crt_pkg::S_SEL);
  assign cmd.link    = (state_r == crt_pkg::S_LINK);
  assign cmd.obj     = (state_r == crt_pkg::S_OBJ);
  assign cmd.commit  = (state_r == crt_pkg::S_UPD) && stat.out_free;

endmodule

// ===== sv/crt_dp.sv =====
// Datapath of the contact reference-count tracker: contact and object tables,
// parallel compare, slot selection, count update and the output register.
// Depends on crt_pkg; driven by crt_ctrl through cmd_t.
module crt_dp #(
  parameter int MAX_CONTACTS = crt_pkg::MAX_CONTACTS_DEF,
  parameter int MAX_OBJECTS  = crt_pkg::MAX_OBJECTS_DEF,
  parameter int KEY_BITS     = crt_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  crt_pkg::cmd_t                cmd,
  output crt_pkg::stat_t               stat,
  input  logic [crt_pkg::ACTION_W-1:0] in_action,
  input  logic [crt_pkg::KEY_W-1:0]    in_contact_key,
  input  logic [crt_pkg::OBJ_W-1:0]    in_peer_object,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [crt_pkg::RES_W-1:0]    out_event_res,
  output logic [crt_pkg::OBJ_W-1:0]    out_event_object,
  output logic                         out_table_full
);

  localparam int KW  = (KEY_BITS < crt_pkg::KEY_W) ? KEY_BITS : crt_pkg::KEY_W;
  localparam int CIW = $clog2(MAX_CONTACTS);
  localparam int OIW = $clog2(MAX_OBJECTS);
  localparam int CW  = $clog2(MAX_CONTACTS + 1);

  // captured item
  logic [crt_pkg::ACTION_W-1:0] act_r;
  logic [KW-1:0]                key_r;
  logic [crt_pkg::OBJ_W-1:0]    obj_r;

  // contact table
  logic [MAX_CONTACTS-1:0]      c_vld_r;
  logic [KW-1:0]                c_key_r  [MAX_CONTACTS];
  logic [OIW-1:0]               c_link_r [MAX_CONTACTS];

  // object table
  logic [MAX_OBJECTS-1:0]       o_vld_r;
  logic [crt_pkg::OBJ_W-1:0]    o_val_r [MAX_OBJECTS];
  logic [CW-1:0]                o_cnt_r [MAX_OBJECTS];

  // compare results
  logic [MAX_CONTACTS-1:0]      c_hitv_r, c_freev_r;
  logic [MAX_OBJECTS-1:0]       o_hitv_r, o_freev_r;

  // selected slots
  logic                         c_hit, c_fok, o_hit, o_fok;
  logic [CIW-1:0]               c_idx, c_fidx;
  logic [OIW-1:0]               o_idx, o_fidx;
  logic                         c_hit_r, c_fok_r, o_hit_r, o_fok_r;
  logic [CIW-1:0]               c_idx_r, c_fidx_r;
  logic [OIW-1:0]               o_idx_r, o_fidx_r;

  // read data
  logic [OIW-1:0]               link_r;
  logic [OIW-1:0]               oi;
  logic [OIW-1:0]               oidx_r;
  logic [CW-1:0]                cnt_r;
  logic [crt_pkg::OBJ_W-1:0]    oval_r;
  logic                         ovld_rd_r;

  // update decisions
  crt_pkg::event_t              res;
  logic [crt_pkg::OBJ_W-1:0]    eobj;
  logic                         full;
  logic                         c_set, c_clr, o_new, o_clr, cnt_we, clear_all;
  logic [CW-1:0]                cnt_new;

  // output register
  logic                         out_valid_r;
  logic [crt_pkg::RES_W-1:0]    res_r;
  logic [crt_pkg::OBJ_W-1:0]    eobj_r;
  logic                         full_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      key_r <= in_contact_key[KW-1:0];
      obj_r <= in_peer_object;
    end
  end

  // parallel compare against every slot
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      for (int i = 0; i < MAX_CONTACTS; i++) begin
        c_hitv_r[i] <= c_vld_r[i] && (c_key_r[i] == key_r);
      end
      for (int j = 0; j < MAX_OBJECTS; j++) begin
        o_hitv_r[j] <= o_vld_r[j] && (o_val_r[j] == obj_r);
      end
      c_freev_r <= ~c_vld_r;
      o_freev_r <= ~o_vld_r;
    end
  end

  // lowest set bit wins
  always_comb begin
    c_hit  = 1'b0;
    c_idx  = '0;
    c_fok  = 1'b0;
    c_fidx = '0;
    for (int i = MAX_CONTACTS - 1; i >= 0; i--) begin
      if (c_hitv_r[i]) begin
        c_hit = 1'b1;
        c_idx = CIW'(i);
      end
      if (c_freev_r[i]) begin
        c_fok  = 1'b1;
        c_fidx = CIW'(i);
      end
    end
  end

  always_comb begin
    o_hit  = 1'b0;
    o_idx  = '0;
    o_fok  = 1'b0;
    o_fidx = '0;
    for (int j = MAX_OBJECTS - 1; j >= 0; j--) begin
      if (o_hitv_r[j]) begin
        o_hit = 1'b1;
        o_idx = OIW'(j);
      end
      if (o_freev_r[j]) begin
        o_fok  = 1'b1;
        o_fidx = OIW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      c_hit_r  <= c_hit;
      c_idx_r  <= c_idx;
      c_fok_r  <= c_fok;
      c_fidx_r <= c_fidx;
      o_hit_r  <= o_hit;
      o_idx_r  <= o_idx;
      o_fok_r  <= o_fok;
      o_fidx_r <= o_fidx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.link) begin
      link_r <= c_link_r[c_idx_r];
    end
  end

  // begin works on the matched or a fresh object slot, end on the linked one
  assign oi = (act_r == crt_pkg::ACT_BEGIN) ? (o_hit_r ? o_idx_r : o_fidx_r) : link_r;

  always_ff @(posedge clk) begin
    if (cmd.obj) begin
      oidx_r    <= oi;
      cnt_r     <= o_cnt_r[oi];
      oval_r    <= o_val_r[oi];
      ovld_rd_r <= o_vld_r[oi];
    end
  end

  always_comb begin
    res       = crt_pkg::EV_NONE;
    eobj      = '0;
    full      = 1'b0;
    c_set     = 1'b0;
    c_clr     = 1'b0;
    o_new     = 1'b0;
    o_clr     = 1'b0;
    cnt_we    = 1'b0;
    cnt_new   = '0;
    clear_all = 1'b0;
    unique case (act_r)
      crt_pkg::ACT_BEGIN: begin
        if (!c_hit_r) begin
          if (!c_fok_r || (!o_hit_r && !o_fok_r)) begin
            full = 1'b1;
          end else begin
            c_set  = 1'b1;
            cnt_we = 1'b1;
            if (!o_hit_r) begin
              o_new   = 1'b1;
              cnt_new = CW'(1);
            end else begin
              cnt_new = cnt_r + CW'(1);
            end
            if (cnt_new == CW'(1)) begin
              res  = crt_pkg::EV_ENTER;
              eobj = obj_r;
            end
          end
        end
      end
      crt_pkg::ACT_END: begin
        if (c_hit_r) begin
          c_clr = 1'b1;
          if (ovld_rd_r) begin
            cnt_we  = 1'b1;
            cnt_new = (cnt_r != '0) ? cnt_r - CW'(1) : '0;
            if (cnt_new == '0) begin
              res   = crt_pkg::EV_EXIT;
              eobj  = oval_r;
              o_clr = 1'b1;
            end
          end
        end
      end
      crt_pkg::ACT_CLEAR: clear_all = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= '0;
      o_vld_r <= '0;
    end else if (cmd.commit) begin
      if (clear_all) begin
        c_vld_r <= '0;
        o_vld_r <= '0;
      end
      if (c_set) c_vld_r[c_fidx_r] <= 1'b1;
      if (c_clr) c_vld_r[c_idx_r]  <= 1'b0;
      if (o_new) o_vld_r[oidx_r]   <= 1'b1;
      if (o_clr) o_vld_r[oidx_r]   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (c_set) begin
        c_key_r[c_fidx_r]  <= key_r;
        c_link_r[c_fidx_r] <= oidx_r;
      end
      if (o_new)  o_val_r[oidx_r] <= obj_r;
      if (cnt_we) o_cnt_r[oidx_r] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r  <= res;
      eobj_r <= eobj;
      full_r <= full;
    end
  end

  assign stat.out_free    = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_event_res    = res_r;
  assign out_event_object = eobj_r;
  assign out_table_full   = full_r;

endmodule

// ===== sv/contact_refcount_tracker_top.sv =====
// Top level of the contact reference-count tracker.
// Depends on crt_pkg, crt_if, crt_ctrl and crt_dp.
//
//   channel  direction  beat holds
//   in_ch    sink       action, contact_key, peer_object
//   out_ch   source     event_res, event_object, table_full
//
// One item at a time: the result register is loaded after the parallel compare,
// slot select, link read, object read and update steps, in that order.
// The update cycle waits while the output register holds an untaken beat;
// the input reopens in the cycle the result beat appears.
// rst_n is synchronous; reset empties both tables at once through valid bits.
module contact_refcount_tracker_top #(
  parameter int MAX_CONTACTS = crt_pkg::MAX_CONTACTS_DEF,
  parameter int MAX_OBJECTS  = crt_pkg::MAX_OBJECTS_DEF,
  parameter int KEY_BITS     = crt_pkg::KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  crt_in_if.sink    in_ch,
  crt_out_if.source out_ch
);

  crt_pkg::cmd_t  cmd;
  crt_pkg::stat_t stat;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crt_dp #(
    .MAX_CONTACTS (MAX_CONTACTS),
    .MAX_OBJECTS  (MAX_OBJECTS),
    .KEY_BITS     (KEY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_ch.action),
    .in_contact_key   (in_ch.contact_key),
    .in_peer_object   (in_ch.peer_object),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_event_res    (out_ch.event_res),
    .out_event_object (out_ch.event_object),
    .out_table_full   (out_ch.table_full)
  );

endmodule

// ===== sv/crt_chk.sv =====
// Port-level checks for the contact reference-count tracker.
// Depends on crt_pkg; bound to contact_refcount_tracker_top below.
module crt_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [crt_pkg::RES_W-1:0] out_event_res,
  input logic [crt_pkg::OBJ_W-1:0] out_event_object,
  input logic                      out_table_full
);

  // one item in flight: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // a new result only appears after work with the input closed
  a_rise_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res)
      && $stable(out_event_object) && $stable(out_table_full))
    else $error("stalled result beat changed");

  // a dropped begin or a silent item carries no event object
  a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_table_full || out_event_res == crt_pkg::EV_NONE)
      |-> out_event_res == crt_pkg::EV_NONE && out_event_object == '0)
    else $error("event reported with a dropped or silent item");

endmodule

bind contact_refcount_tracker_top crt_chk u_crt_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_event_res    (out_ch.event_res),
  .out_event_object (out_ch.event_object),
  .out_table_full   (out_ch.table_full)
);

// ===== sim/tb_top.sv =====
// Testbench for contact_refcount_tracker_top: directed contact sequences, then
// random bursts over small and large key and object pools, checked beat by beat.
// Depends on crt_pkg, crt_if and the tracker RTL.
module tb_top;

  localparam int ACT_BITS = crt_pkg::ACTION_W;
  localparam int KEY_BITS = crt_pkg::KEY_W;
  localparam int OBJ_BITS = crt_pkg::OBJ_W;
  localparam logic [ACT_BITS-1:0] ACT_SPARE = 2'd3;  // undefined action code
  localparam int N_CONTACTS   = crt_pkg::MAX_CONTACTS_DEF;
  localparam int N_OBJECTS    = crt_pkg::MAX_OBJECTS_DEF;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [ACT_BITS-1:0] action;
    logic [KEY_BITS-1:0] key;
    logic [OBJ_BITS-1:0] obj;
    logic                drain_first;  // wait for every result before offering
  } contact_req_t;

  typedef struct packed {
    crt_pkg::event_t     ev;
    logic [OBJ_BITS-1:0] obj;
    logic                full;
  } contact_evt_t;

  logic clk;
  logic rst_n;

  crt_in_if  in_ch ();
  crt_out_if out_ch ();

  contact_refcount_tracker_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the two tables
  bit                  open_valid [N_CONTACTS];
  logic [KEY_BITS-1:0] open_key   [N_CONTACTS];
  logic [OBJ_BITS-1:0] open_obj   [N_CONTACTS];
  bit                  obj_valid  [N_OBJECTS];
  logic [OBJ_BITS-1:0] obj_id     [N_OBJECTS];
  int                  obj_refs   [N_OBJECTS];

  contact_req_t contact_reqs[$];
  contact_evt_t expected_events[$];
  contact_req_t cur;
  bit           offering;
  int           sent;
  int           in_beats;
  int           out_beats;
  int           errors;
  int           burst_left;
  int           gap_left;
  int           hold_left;
  int           holds_done;
  bit [31:0]    rx_cycle;
  int           cycle_count;

  function automatic int find_contact(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < N_CONTACTS; i++)
      if (open_valid[i] && open_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int find_object(logic [OBJ_BITS-1:0] obj);
    for (int i = 0; i < N_OBJECTS; i++)
      if (obj_valid[i] && obj_id[i] == obj) return i;
    return -1;
  endfunction

  // Apply one request to the mirror and return the event it raises
  function automatic contact_evt_t track_contact(contact_req_t req);
    contact_evt_t r;
    int c;
    int o;
    bit fresh;
    logic [OBJ_BITS-1:0] cobj;
    r = '{ev: crt_pkg::EV_NONE, obj: '0, full: 1'b0};
    case (req.action)
      crt_pkg::ACT_BEGIN: begin
        if (find_contact(req.key) < 0) begin
          c = -1;
          for (int i = N_CONTACTS - 1; i >= 0; i--)
            if (!open_valid[i]) c = i;
          o = find_object(req.obj);
          fresh = (o < 0);
          if (fresh)
            for (int i = N_OBJECTS - 1; i >= 0; i--)
              if (!obj_valid[i]) o = i;
          if (c < 0 || o < 0) begin
            r.full = 1'b1;
          end else begin
            open_valid[c] = 1'b1;
            open_key[c]   = req.key;
            open_obj[c]   = req.obj;
            if (fresh) begin
              obj_valid[o] = 1'b1;
              obj_id[o]    = req.obj;
              obj_refs[o]  = 0;
            end
            obj_refs[o]++;
            if (obj_refs[o] == 1) begin
              r.ev  = crt_pkg::EV_ENTER;
              r.obj = req.obj;
            end
          end
        end
      end
      crt_pkg::ACT_END: begin
        c = find_contact(req.key);
        if (c >= 0) begin
          cobj = open_obj[c];
          o = find_object(cobj);
          if (o >= 0) begin
            if (obj_refs[o] > 0) obj_refs[o]--;
            if (obj_refs[o] == 0) begin
              r.ev  = crt_pkg::EV_EXIT;
              r.obj = cobj;
              obj_valid[o] = 1'b0;
            end
          end
          open_valid[c] = 1'b0;
        end
      end
      crt_pkg::ACT_CLEAR: begin
        for (int i = 0; i < N_CONTACTS; i++) open_valid[i] = 1'b0;
        for (int i = 0; i < N_OBJECTS; i++) obj_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void queue_req(logic [ACT_BITS-1:0] action, logic [KEY_BITS-1:0] key,
                                    logic [OBJ_BITS-1:0] obj, bit drain_first);
    contact_reqs.push_back('{action: action, key: key, obj: obj, drain_first: drain_first});
  endfunction

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = crt_pkg::ACT_BEGIN;
    in_ch.contact_key = '0;
    in_ch.peer_object = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Feed pending requests in bursts separated by random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (offering && in_beats == sent) offering = 1'b0;
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (contact_reqs.size() > 0 &&
                     (!contact_reqs[0].drain_first || expected_events.size() == 0)) begin
          cur = contact_reqs.pop_front();
          offering = 1'b1;
          sent++;
          in_ch.action      <= cur.action;
          in_ch.contact_key <= cur.key;
          in_ch.peer_object <= cur.obj;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              3:       gap_left = $urandom_range(8, 24);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end
      end
      in_ch.valid <= offering;
    end
  end

  // Receiver: shifting stall patterns, plus two long hold-offs to back the block up
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_done < 2 && out_beats >= 300 + 400 * holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_cycle[8:6])
          3'd0, 3'd1: out_ch.ready <= 1'b1;
          3'd2, 3'd3: out_ch.ready <= ($urandom_range(0, 1) != 0);
          3'd4:       out_ch.ready <= (rx_cycle % 7) >= 3;
          3'd5:       out_ch.ready <= ($urandom_range(0, 9) != 0);
          3'd6:       out_ch.ready <= rx_cycle[2];
          default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Predict on each input beat, compare on each result beat
  always @(posedge clk) begin
    contact_evt_t e;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_events.push_back(track_contact(cur));
        in_beats++;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_beats++;
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat ev %0d obj %0d full %0d", $time,
                   out_ch.event_res, out_ch.event_object, out_ch.table_full);
        end else begin
          e = expected_events.pop_front();
          if (out_ch.event_res !== e.ev) begin
            errors++;
            $display("%0t: event_res expected %0d actual %0d", $time, e.ev,
                     out_ch.event_res);
          end
          if (out_ch.event_object !== e.obj) begin
            errors++;
            $display("%0t: event_object expected %0d actual %0d", $time, e.obj,
                     out_ch.event_object);
          end
          if (out_ch.table_full !== e.full) begin
            errors++;
            $display("%0t: table_full expected %0d actual %0d", $time, e.full,
                     out_ch.table_full);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [KEY_BITS-1:0] key_pool [64];
    logic [OBJ_BITS-1:0] obj_pool [32];
    int made;
    int seg_len;
    int nkeys;
    int nobjs;
    int begin_w;
    int clear_w;
    int r;
    bit drain;

    burst_left = 1;

    // Open, reopen, share an object, unknown end, spare action, exit
    queue_req(crt_pkg::ACT_BEGIN, 32'h0000_0000, 8'h00, 1'b0);
    queue_req(crt_pkg::ACT_BEGIN, 32'h0000_0000, 8'hFF, 1'b0);
    queue_req(crt_pkg::ACT_BEGIN, 32'hFFFF_FFFF, 8'h00, 1'b0);
    queue_req(crt_pkg::ACT_BEGIN, 32'h1234_5678, 8'hFF, 1'b0);
    queue_req(crt_pkg::ACT_END,   32'h0000_0000, 8'hFF, 1'b0);
    queue_req(crt_pkg::ACT_END,   32'hDEAD_BEEF, 8'h00, 1'b0);
    queue_req(ACT_SPARE,          32'hFFFF_FFFF, 8'hFF, 1'b0);
    queue_req(crt_pkg::ACT_END,   32'hFFFF_FFFF, 8'h00, 1'b0);
    queue_req(crt_pkg::ACT_END,   32'hFFFF_FFFF, 8'h00, 1'b0);
    // Fill the object table, then one more new object is dropped
    for (int j = 1; j <= N_OBJECTS; j++)
      queue_req(crt_pkg::ACT_BEGIN, KEY_BITS'(32'hA5A5_0000 + j), OBJ_BITS'(j * 13), 1'b0);
    queue_req(crt_pkg::ACT_CLEAR, 32'h5A5A_5A5A, 8'h5A, 1'b0);
    queue_req(crt_pkg::ACT_END,   32'h1234_5678, 8'h00, 1'b0);

    // Random segments, each over fresh key and object pools
    made = 0;
    drain = 1'b1;
    while (made < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 80);
      nkeys = $urandom_range(0, 1) ? $urandom_range(4, 12) : $urandom_range(34, 60);
      nobjs = $urandom_range(0, 1) ? $urandom_range(2, 6) : $urandom_range(17, 30);
      begin_w = $urandom_range(40, 75);
      clear_w = $urandom_range(0, 1) ? 0 : 3;
      for (int i = 0; i < 64; i++) key_pool[i] = $urandom;
      for (int i = 0; i < 32; i++) obj_pool[i] = OBJ_BITS'($urandom_range(0, 255));
      if ($urandom_range(0, 2) == 0) drain = 1'b1;
      if ($urandom_range(0, 1)) begin
        queue_req(crt_pkg::ACT_CLEAR, $urandom, OBJ_BITS'($urandom_range(0, 255)), drain);
        made++;
        drain = 1'b0;
      end
      for (int i = 0; i < seg_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < begin_w) begin
          queue_req(crt_pkg::ACT_BEGIN, key_pool[$urandom_range(0, nkeys - 1)],
                    obj_pool[$urandom_range(0, nobjs - 1)], drain);
        end else if (r < 92 - clear_w) begin
          queue_req(crt_pkg::ACT_END, key_pool[$urandom_range(0, nkeys - 1)],
                    OBJ_BITS'($urandom_range(0, 255)), drain);
        end else if (r < 96 - clear_w) begin
          // noise: a key outside the pool
          queue_req($urandom_range(0, 1) ? crt_pkg::ACT_BEGIN : crt_pkg::ACT_END, $urandom,
                    OBJ_BITS'($urandom_range(0, 255)), drain);
        end else if (r < 100 - clear_w) begin
          queue_req(ACT_SPARE, $urandom, OBJ_BITS'($urandom_range(0, 255)), drain);
        end else begin
          queue_req(crt_pkg::ACT_CLEAR, $urandom, OBJ_BITS'($urandom_range(0, 255)), drain);
        end
        made++;
        drain = 1'b0;
      end
    end

    while (contact_reqs.size() > 0 || offering || expected_events.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && expected_events.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
